@@ sv/accel_tilt_angle_filter_macros.svh @@
// Assertion helpers shared by the tilt filter modules.
`ifndef ACCEL_TILT_ANGLE_FILTER_MACROS_SVH
`define ACCEL_TILT_ANGLE_FILTER_MACROS_SVH
`define ATF_ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ATF_ASSERT(lbl, prop, msg) \
  `ATF_ASSERT_IMPL(lbl, clk_i, rst_ni, prop, msg)
`endif

@@ sv/atf_pkg.sv @@
package atf_pkg;
  localparam int CordicSteps = 16;
  localparam int AtanLen = 24;
  localparam int StepW = $clog2(AtanLen + 1);
  localparam int QueueDepth = 2;
  localparam logic signed [35:0] PiQ30 = 36'sd3373259426;
  localparam logic signed [23:0] DegQ16 = 24'sd3754885;
  localparam int RollLimit = 23040;
  localparam int PitchLimit = 11520;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
  } filt_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ROLL_INIT, S_ROLL_ITER, S_SQ_Y, S_SQ_Z, S_SQRT, S_PITCH_INIT,
    S_PITCH_ITER, S_CONV, S_CONV2, S_OUT
  } back_state_e;

  function automatic logic signed [35:0] atan_q30(input logic [StepW-1:0] i);
    case (i)
      0: atan_q30 = 36'sd843314857;  1: atan_q30 = 36'sd497837829;
      2: atan_q30 = 36'sd263043837;  3: atan_q30 = 36'sd133525159;
      4: atan_q30 = 36'sd67021687;   5: atan_q30 = 36'sd33543516;
      6: atan_q30 = 36'sd16775851;   7: atan_q30 = 36'sd8388437;
      8: atan_q30 = 36'sd4194283;    9: atan_q30 = 36'sd2097149;
      default: atan_q30 = (i < StepW'(AtanLen)) ?
        (36'sd1 <<< (30 - int'(i))) : 36'sd0;
    endcase
  endfunction
endpackage

@@ sv/atf_front.sv @@
module atf_front import atf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [47:0]       in_data_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output filt_t             q_data_o
);
  logic [15:0] coef_q;
  logic [1:0] axis_q, axis_d;
  logic busy_q, busy_d;
  logic [47:0] samp_q;
  filt_t filt_q, filt_d;
  filt_t ent_q [QueueDepth];
  logic [1:0] cnt_q, cnt_d;
  logic wr_q, rd_q;
  logic signed [31:0] f_cur, prod_lo;
  logic signed [15:0] x_cur;
  logic signed [48:0] fa;
  logic signed [33:0] xa;
  logic signed [31:0] f_new;
  logic push, pop;

  assign in_ready_o = !busy_q && (cnt_q < 2'(QueueDepth));
  assign q_valid_o = cnt_q != 2'd0;
  assign q_data_o = ent_q[rd_q];
  assign pop = q_valid_o && q_ready_i;

  always_comb begin
    case (axis_q)
      2'd0: begin f_cur = filt_q.fx; x_cur = samp_q[15:0]; end
      2'd1: begin f_cur = filt_q.fy; x_cur = samp_q[31:16]; end
      default: begin f_cur = filt_q.fz; x_cur = samp_q[47:32]; end
    endcase
    fa = f_cur * $signed({1'b0, coef_q});
    xa = x_cur * $signed(18'sd65536 - $signed({2'b0, coef_q}));
    prod_lo = fa[47:16];
    f_new = 32'(xa) + prod_lo;
    filt_d = filt_q;
    axis_d = axis_q;
    busy_d = busy_q;
    push = 1'b0;
    if (busy_q) begin
      case (axis_q)
        2'd0: filt_d.fx = f_new;
        2'd1: filt_d.fy = f_new;
        default: filt_d.fz = f_new;
      endcase
      if (axis_q == 2'd2) begin
        axis_d = 2'd0; busy_d = 1'b0; push = 1'b1;
      end else axis_d = axis_q + 2'd1;
    end else if (in_valid_i && in_ready_o) begin
      busy_d = 1'b1;
    end
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0; axis_q <= '0; busy_q <= 1'b0; filt_q <= '0;
      cnt_q <= '0; wr_q <= 1'b0; rd_q <= 1'b0;
    end else begin
      if (cfg_we_i) coef_q <= cfg_wdata_i;
      axis_q <= axis_d; busy_q <= busy_d; filt_q <= filt_d; cnt_q <= cnt_d;
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && in_valid_i && in_ready_o) samp_q <= in_data_i;
    if (push) ent_q[wr_q] <= filt_d;
  end

  `include "accel_tilt_angle_filter_macros.svh"
  `ATF_ASSERT(a_cnt_max, cnt_q <= 2'(QueueDepth), "queue overflow")
  `ATF_ASSERT(a_push_room, push |-> cnt_q < 2'(QueueDepth) || pop, "push into full queue")
  `ATF_ASSERT(a_busy_axis, !busy_q |-> axis_q == 2'd0, "axis counter idle mismatch")
endmodule

@@ sv/atf_back.sv @@
module atf_back import atf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  filt_t       q_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_data_o
);
  back_state_e st_q, st_d;
  filt_t f_q;
  logic signed [35:0] x_q, y_q, z_q;
  logic [StepW-1:0] i_q;
  logic [63:0] acc_q, v_q, r_q, b_q;
  logic [1:0] sq_q;
  logic signed [15:0] roll_q;
  logic signed [14:0] pitch_q;
  logic signed [59:0] prod_q;
  logic signed [31:0] sq_src;
  logic [63:0] sq;
  logic signed [35:0] xs, ys, dz;
  logic [63:0] rb;
  logic signed [27:0] deg;
  logic signed [27:0] lim;
  logic signed [15:0] sat;

  assign q_ready_o = st_q == S_IDLE;
  assign out_valid_o = st_q == S_OUT;
  assign out_data_o = {1'b0, pitch_q, roll_q};

  always_comb begin
    sq_src = (st_q == S_SQ_Y) ? f_q.fy : f_q.fz;
    sq = sq_src * sq_src;
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    dz = atan_q30(i_q);
    rb = r_q + b_q;
    deg = 28'(prod_q >>> 39);
    lim = !sq_q[0] ? 28'(RollLimit) : 28'(PitchLimit);
    if (deg > lim) sat = 16'(lim);
    else if (deg < -lim) sat = 16'(-lim);
    else sat = 16'(deg);
    st_d = st_q;
    case (st_q)
      S_IDLE: if (q_valid_i) st_d = S_ROLL_INIT;
      S_ROLL_INIT: st_d = S_ROLL_ITER;
      S_ROLL_ITER: if (i_q == StepW'(CordicSteps - 1)) st_d = S_SQ_Y;
      S_SQ_Y: st_d = S_SQ_Z;
      S_SQ_Z: st_d = S_SQRT;
      S_SQRT: if (b_q == 64'd0) st_d = S_PITCH_INIT;
      S_PITCH_INIT: st_d = S_PITCH_ITER;
      S_PITCH_ITER: if (i_q == StepW'(CordicSteps - 1)) st_d = S_CONV;
      S_CONV: st_d = S_CONV2;
      S_CONV2: st_d = sq_q[0] ? S_OUT : S_CONV;
      S_OUT: if (out_ready_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= S_IDLE;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin f_q <= q_data_i; sq_q <= '0; end
      S_ROLL_INIT, S_PITCH_INIT: begin
        logic signed [35:0] ax, ay;
        ax = (st_q == S_ROLL_INIT) ? 36'(f_q.fz) : $signed({3'b0, r_q[32:0]});
        ay = (st_q == S_ROLL_INIT) ? 36'(f_q.fy) : 36'(f_q.fx);
        i_q <= '0;
        if (ax < 0) begin
          x_q <= -ax; y_q <= -ay; z_q <= (ay >= 0) ? PiQ30 : -PiQ30;
        end else begin
          x_q <= ax; y_q <= ay; z_q <= '0;
        end
        sq_q[1] <= (ax == 0) && (ay == 0);
      end
      S_ROLL_ITER, S_PITCH_ITER: begin
        i_q <= i_q + StepW'(1);
        if (y_q >= 0) begin
          x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + dz;
        end else begin
          x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - dz;
        end
        if (i_q == StepW'(CordicSteps - 1) && st_q == S_ROLL_ITER)
          acc_q <= sq_q[1] ? 64'd0 : 64'(z_q + ((y_q >= 0) ? dz : -dz));
      end
      S_SQ_Y: acc_q <= acc_q;
      default: ;
    endcase
    if (st_q == S_ROLL_ITER && i_q == StepW'(CordicSteps - 1)) v_q <= '0;
    if (st_q == S_SQ_Y) v_q <= sq;
    if (st_q == S_SQ_Z) begin
      v_q <= v_q + sq; r_q <= '0; b_q <= 64'd1 << 62;
    end
    if (st_q == S_SQRT && b_q != 64'd0) begin
      if (v_q >= rb) begin
        v_q <= v_q - rb; r_q <= (r_q >> 1) + b_q;
      end else r_q <= r_q >> 1;
      b_q <= b_q >> 2;
    end
    if (st_q == S_PITCH_ITER && i_q == StepW'(CordicSteps - 1))
      z_q <= sq_q[1] ? 36'sd0 : z_q + ((y_q >= 0) ? dz : -dz);
    if (st_q == S_CONV)
      prod_q <= 60'(sq_q[0] ? z_q : $signed(acc_q[35:0])) * DegQ16 + (60'sd1 <<< 38);
    if (st_q == S_CONV2) begin
      if (!sq_q[0]) roll_q <= sat;
      else pitch_q <= 15'(-sat);
      sq_q[0] <= 1'b1;
    end
  end

  `include "accel_tilt_angle_filter_macros.svh"
  `ATF_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")
  `ATF_ASSERT(a_no_take, out_valid_o |-> !q_ready_o, "took item while result pending")
  `ATF_ASSERT(a_iter_rng, st_q == S_ROLL_ITER |-> i_q < StepW'(CordicSteps), "step overrun")
endmodule

@@ sv/accel_tilt_angle_filter.sv @@
// An input transfer passes through the filter, the queue handoff, the roll CORDIC, the
// squares of y and z, the square root, the pitch CORDIC, conversion and output.
// The iterative back end takes no new sample until its result has been transferred;
// a two-entry queue lets the filter take the next samples meanwhile.
// Reset (rst_ni low, asynchronous) clears filter state, coefficient and queue.
module accel_tilt_angle_filter import atf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // accel_x, accel_y, accel_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // roll_angle, pitch_angle, zero pad
);
  logic q_valid, q_ready;
  filt_t q_data;

  atf_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_data_i(s_axis_tdata),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  atf_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(m_axis_tdata)
  );
endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int WatchdogLimit = 6000;
  localparam int DrainCycles = 120;
  localparam int LongHoldCycles = 600;
  localparam longint TiltPiQ30 = 64'sd3373259426;
  localparam longint TiltDegQ16 = 64'sd3754885;
  localparam longint TiltRollMax = 23040;
  localparam longint TiltPitchMax = 11520;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
  } tilt_t;

  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    bit                 typed;
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
  } sample_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  accel_tilt_angle_filter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  longint atan_step[24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
    8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048, 1024, 512, 256, 128
  };

  longint lp_coef;
  longint lp_fx, lp_fy, lp_fz;
  tilt_t  angle_q[$];
  int     errors;
  int     samples_sent;
  int     angles_seen;
  int     idle_cycles;
  int     burst_left;
  bit     hold_request;
  bit     hold_done;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint lowpass_step(longint f, longint x);
    longint s;
    s = x * (65536 - lp_coef) + ((f * lp_coef) >>> 16);
    return longint'(int'(s));
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? TiltPiQ30 : -TiltPiQ30;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < atf_pkg::CordicSteps && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step[i];
      end
    end
    return z;
  endfunction

  function automatic longint to_fine_degrees(longint z, longint lim);
    longint d;
    d = (z * TiltDegQ16 + (64'sd1 <<< 38)) >>> 39;
    if (d > lim) d = lim;
    if (d < -lim) d = -lim;
    return d;
  endfunction

  function automatic tilt_t tilt_update(logic signed [15:0] ax, logic signed [15:0] ay,
                                        logic signed [15:0] az);
    tilt_t  t;
    longint mag;
    lp_fx = lowpass_step(lp_fx, longint'(ax));
    lp_fy = lowpass_step(lp_fy, longint'(ay));
    lp_fz = lowpass_step(lp_fz, longint'(az));
    t.roll = 16'(to_fine_degrees(vector_angle(lp_fy, lp_fz), TiltRollMax));
    mag = floor_sqrt(longint'(lp_fy * lp_fy) + longint'(lp_fz * lp_fz));
    t.pitch = 15'(-to_fine_degrees(vector_angle(lp_fx, mag), TiltPitchMax));
    return t;
  endfunction

  task automatic send_sample(sample_row_t row);
    tilt_t t;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row.az, row.ay, row.ax};
    forever begin
      @(negedge clk_i);
      if (s_axis_tready) break;
    end
    @(posedge clk_i);
    t = tilt_update(row.ax, row.ay, row.az);
    if (row.typed) begin
      t.roll  = row.roll;
      t.pitch = row.pitch;
    end
    angle_q.push_back(t);
    samples_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 90)) @(posedge clk_i);
      end
    end
  endtask

  task automatic write_coef(logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lp_coef = longint'(value);
  endtask

  function automatic logic signed [15:0] pick_axis();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'($urandom_range(0, 65535));
      2:       return 16'sd0;
      3:       return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      default: return 16'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  task automatic random_samples(int count);
    sample_row_t row;
    for (int n = 0; n < count; n++) begin
      row.typed = 1'b0;
      row.ax = pick_axis();
      row.ay = pick_axis();
      row.az = pick_axis();
      if ($urandom_range(0, 15) == 0) begin
        row.ay = 16'sd0;
        row.az = -16'($urandom_range(1, 32768));
      end
      send_sample(row);
    end
  endtask

  sample_row_t directed[] = '{
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 15'sd0},
    '{16'sd100, 16'sd0, 16'sd0, 1'b0, 16'sd0, 15'sd0},
    '{16'sd0, 16'sd0, 16'sd1000, 1'b0, 16'sd0, 15'sd0},
    '{16'sd0, 16'sd0, -16'sd1000, 1'b0, 16'sd0, 15'sd0},
    '{16'sd0, 16'sd0, -16'sd32768, 1'b0, 16'sd0, 15'sd0},
    '{16'sd0, 16'sd1000, 16'sd0, 1'b0, 16'sd0, 15'sd0},
    '{16'sd0, -16'sd1000, 16'sd0, 1'b0, 16'sd0, 15'sd0},
    '{16'sh7fff, 16'sd0, 16'sd0, 1'b0, 16'sd0, 15'sd0},
    '{16'sh8000, 16'sd0, 16'sd0, 1'b0, 16'sd0, 15'sd0},
    '{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, 16'sd0, 15'sd0},
    '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 16'sd0, 15'sd0},
    '{16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, 16'sd0, 15'sd0},
    '{16'sh5555, 16'shaaaa, 16'sh5555, 1'b0, 16'sd0, 15'sd0},
    '{16'shaaaa, 16'sh5555, 16'shaaaa, 1'b0, 16'sd0, 15'sd0},
    '{16'sd1, -16'sd1, 16'sd1, 1'b0, 16'sd0, 15'sd0},
    '{-16'sd1, 16'sd0, -16'sd1, 1'b0, 16'sd0, 15'sd0},
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 15'sd0}
  };

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    lp_coef = 0;
    lp_fx = 0;
    lp_fy = 0;
    lp_fz = 0;
    errors = 0;
    samples_sent = 0;
    burst_left = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_sample(directed[i]);
    random_samples(400);
    write_coef(16'hffff);
    random_samples(300);
    write_coef(16'h8000);
    random_samples(400);
    write_coef(16'($urandom_range(1, 65534)));
    random_samples(400);
    write_coef(16'h0001);
    random_samples(200);
    write_coef(16'h0000);
    random_samples(230);
    s_axis_tvalid <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d samples over coefficients 0, 1, half, max and random;", samples_sent);
    $display("checked %0d roll/pitch transfers, with one long output stall.", angles_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    int phase;
    m_axis_tready = 1'b0;
    hold_done = 1'b0;
    phase = 0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && angles_seen >= 300) begin
        m_axis_tready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end
      phase = (phase + 1) % 192;
      if (phase < 64) begin
        m_axis_tready <= 1'b1;
      end else if (phase < 128) begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end else begin
        m_axis_tready <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  initial angles_seen = 0;

  always @(negedge clk_i) begin
    tilt_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      angles_seen++;
      if (angle_q.size() == 0) begin
        $error("unexpected transfer: roll %0d pitch %0d",
               $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[30:16]));
        errors++;
      end else begin
        want = angle_q.pop_front();
        if (m_axis_tdata[15:0] !== want.roll) begin
          $error("roll_angle: expected %0d, got %0d", want.roll, $signed(m_axis_tdata[15:0]));
          errors++;
        end
        if (m_axis_tdata[30:16] !== want.pitch) begin
          $error("pitch_angle: expected %0d, got %0d", want.pitch,
                 $signed(m_axis_tdata[30:16]));
          errors++;
        end
        if (m_axis_tdata[31] !== 1'b0) begin
          $error("pad: expected 0, got %b", m_axis_tdata[31]);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule
